### src/bfc_pkg.sv
package bfc_pkg;

    localparam int DEF_POOL_DEPTH    = 512;
    localparam int DEF_SIZE_BITS     = 40;
    localparam int DEF_CONTEXT_BITS  = 8;
    localparam int DEF_HANDLE_BITS   = 16;

    localparam int COUNT_OUT_BITS    = 10;
    localparam int TOTAL_BITS        = 49;
    localparam int MAXB_BITS         = 10;
    localparam int DEFAULT_MAX_BLOCKS = 512;

    localparam int CFG_IDX_BITS      = 1;
    localparam int CFG_DATA_BITS     = 10;

    typedef enum logic [1:0] {
        FUNC_ACQUIRE = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_CLEAR   = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_POOL_ENABLE = 1'b0,
        CFG_MAX_BLOCKS  = 1'b1
    } cfg_idx_t;

endpackage

### src/bfc_if.sv
interface bfc_req_if
    import bfc_pkg::*;
#(
    parameter int SIZE_BITS    = DEF_SIZE_BITS,
    parameter int CONTEXT_BITS = DEF_CONTEXT_BITS,
    parameter int HANDLE_BITS  = DEF_HANDLE_BITS
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              func;
    logic [CONTEXT_BITS-1:0] context_id;
    logic [SIZE_BITS-1:0]    size_bytes;
    logic [HANDLE_BITS-1:0]  block_handle;

    modport source (output valid, func, context_id, size_bytes, block_handle, input ready);
    modport sink   (input valid, func, context_id, size_bytes, block_handle, output ready);
endinterface

interface bfc_rsp_if
    import bfc_pkg::*;
#(
    parameter int SIZE_BITS   = DEF_SIZE_BITS,
    parameter int HANDLE_BITS = DEF_HANDLE_BITS
);
    logic                      valid;
    logic                      ready;
    logic                      hit;
    logic                      pooled;
    logic [HANDLE_BITS-1:0]    out_handle;
    logic [SIZE_BITS-1:0]      out_size;
    logic                      stored;
    logic [COUNT_OUT_BITS-1:0] cached_blocks;
    logic [TOTAL_BITS-1:0]     cached_bytes;

    modport source (output valid, hit, pooled, out_handle, out_size, stored, cached_blocks,
                    cached_bytes, input ready);
    modport sink   (input valid, hit, pooled, out_handle, out_size, stored, cached_blocks,
                    cached_bytes, output ready);
endinterface

interface bfc_cfg_if
    import bfc_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/best_fit_block_cache.sv
// Best-fit block cache: pool of freed blocks, kept in release order.
// Channels:
//   req  - one transfer per operation: acquire, release or clear.
//   rsp  - one transfer per operation, in order, with hit/handle/size and
//          the pool counts after the operation.
//   cfg  - register writes (pool_enable, max_blocks); always ready. The
//          user writes only while the block is idle; not enforced by the block.
// Operation flow:
//   release, clear, unused code, acquire with pool disabled: the response
//   is registered in the cycle after the request. acquire: scan of the
//   cached entries; on a hit the list is compacted behind the taken entry.
//   Both phases are bound by the single read port of the entry RAM, one
//   entry per cycle.
// One operation is in flight at a time. The response sits in an output
// register; a new request is taken in the cycle the previous response is
// transferred, so a stalled receiver holds the block in idle.
// Reset: empty pool, zero byte total, pool enabled, limit 512. The entry RAM
// is not cleared; only entries below the count are ever read.
module best_fit_block_cache
    import bfc_pkg::*;
#(
    parameter int POOL_DEPTH   = DEF_POOL_DEPTH,
    parameter int SIZE_BITS    = DEF_SIZE_BITS,
    parameter int CONTEXT_BITS = DEF_CONTEXT_BITS,
    parameter int HANDLE_BITS  = DEF_HANDLE_BITS
) (
    input  logic clk,
    input  logic rst_n,
    bfc_req_if.sink   req,
    bfc_rsp_if.source rsp,
    bfc_cfg_if.sink   cfg
);
    localparam int AW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int LW = (CW > MAXB_BITS + 1) ? CW : MAXB_BITS + 1;
    localparam int WW = CONTEXT_BITS + SIZE_BITS + HANDLE_BITS;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_SHIFT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic                    enable_reg;
    logic [MAXB_BITS-1:0]    max_blocks_reg;
    logic [CW-1:0]           count_reg, count_next;
    logic [TOTAL_BITS-1:0]   total_reg, total_next;

    // operation in flight
    logic [CONTEXT_BITS-1:0] ctx_reg, ctx_next;
    logic [SIZE_BITS-1:0]    size_reg, size_next;

    // scan / shift pointers
    logic [CW-1:0]           rd_idx_reg, rd_idx_next;
    logic                    pend_reg, pend_next;
    logic [CW-1:0]           pend_idx_reg, pend_idx_next;
    logic                    found_reg, found_next;
    logic [CW-1:0]           best_idx_reg, best_idx_next;
    logic [SIZE_BITS-1:0]    best_size_reg, best_size_next;
    logic [HANDLE_BITS-1:0]  best_handle_reg, best_handle_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic                    hit_reg, hit_next;
    logic                    pooled_reg, pooled_next;
    logic [HANDLE_BITS-1:0]  oh_reg, oh_next;
    logic [SIZE_BITS-1:0]    os_reg, os_next;
    logic                    stored_reg, stored_next;

    // RAM
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [WW-1:0]           ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [WW-1:0]           ram_rdata;
    logic [CONTEXT_BITS-1:0] r_ctx;
    logic [SIZE_BITS-1:0]    r_size;
    logic [HANDLE_BITS-1:0]  r_handle;

    logic                    req_xfer;
    logic                    issue;
    logic                    better;
    logic [LW-1:0]           limit;
    func_t                   func_in;

    bfc_ram #(
        .WIDTH (WW),
        .DEPTH (POOL_DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign {r_ctx, r_size, r_handle} = ram_rdata;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign req_xfer  = req.valid && req.ready;
    assign func_in   = func_t'(req.func);

    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = hit_reg;
    assign rsp.pooled        = pooled_reg;
    assign rsp.out_handle    = oh_reg;
    assign rsp.out_size      = os_reg;
    assign rsp.stored        = stored_reg;
    assign rsp.cached_blocks = COUNT_OUT_BITS'(count_reg);
    assign rsp.cached_bytes  = total_reg;

    // effective limit: zero means default, capped at the RAM depth
    always_comb
    begin
        limit = (max_blocks_reg == '0) ? LW'(DEFAULT_MAX_BLOCKS) : LW'(max_blocks_reg);
        if (limit > LW'(POOL_DEPTH))
        begin
            limit = LW'(POOL_DEPTH);
        end
    end

    assign issue     = rd_idx_reg < count_reg;
    assign ram_raddr = rd_idx_reg[AW-1:0];
    assign better    = pend_reg && (r_ctx == ctx_reg) && (r_size >= size_reg) &&
                       (!found_reg || (r_size < best_size_reg));

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        total_next       = total_reg;
        ctx_next         = ctx_reg;
        size_next        = size_reg;
        rd_idx_next      = rd_idx_reg;
        pend_next        = 1'b0;
        pend_idx_next    = rd_idx_reg;
        found_next       = found_reg;
        best_idx_next    = best_idx_reg;
        best_size_next   = best_size_reg;
        best_handle_next = best_handle_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        hit_next         = hit_reg;
        pooled_next      = pooled_reg;
        oh_next          = oh_reg;
        os_next          = os_reg;
        stored_next      = stored_reg;
        ram_we           = 1'b0;
        ram_waddr        = count_reg[AW-1:0];
        ram_wdata        = {req.context_id, req.size_bytes, req.block_handle};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    hit_next    = 1'b0;
                    pooled_next = 1'b0;
                    oh_next     = '0;
                    os_next     = '0;
                    stored_next = 1'b0;
                    case (func_in)
                        FUNC_ACQUIRE:
                        begin
                            if (enable_reg)
                            begin
                                ctx_next    = req.context_id;
                                size_next   = req.size_bytes;
                                rd_idx_next = '0;
                                found_next  = 1'b0;
                                state_next  = ST_SCAN;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                            end
                        end
                        FUNC_RELEASE:
                        begin
                            if (enable_reg && (LW'(count_reg) < limit))
                            begin
                                ram_we      = 1'b1;
                                count_next  = count_reg + 1'b1;
                                total_next  = total_reg + TOTAL_BITS'(req.size_bytes);
                                stored_next = 1'b1;
                            end
                            out_valid_next = 1'b1;
                        end
                        FUNC_CLEAR:
                        begin
                            count_next     = '0;
                            total_next     = '0;
                            out_valid_next = 1'b1;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (better)
                begin
                    found_next       = 1'b1;
                    best_idx_next    = pend_idx_reg;
                    best_size_next   = r_size;
                    best_handle_next = r_handle;
                end
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                    pend_next   = 1'b1;
                end
                else if (!pend_reg)
                begin
                    pooled_next = 1'b1;
                    if (found_reg)
                    begin
                        total_next  = total_reg - TOTAL_BITS'(best_size_reg);
                        rd_idx_next = best_idx_reg + 1'b1;
                        state_next  = ST_SHIFT;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            ST_SHIFT:
            begin
                // entry i+1 read one cycle, written to i the next
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(pend_idx_reg - 1'b1);
                    ram_wdata = ram_rdata;
                end
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                    pend_next   = 1'b1;
                end
                else if (!pend_reg)
                begin
                    count_next     = count_reg - 1'b1;
                    hit_next       = 1'b1;
                    oh_next        = best_handle_reg;
                    os_next        = best_size_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            enable_reg     <= 1'b1;
            max_blocks_reg <= MAXB_BITS'(DEFAULT_MAX_BLOCKS);
            count_reg      <= '0;
            total_reg      <= '0;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg_idx_t'(cfg.index))
                    CFG_POOL_ENABLE: enable_reg     <= cfg.data[0];
                    CFG_MAX_BLOCKS:  max_blocks_reg <= cfg.data;
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg         <= ctx_next;
        size_reg        <= size_next;
        rd_idx_reg      <= rd_idx_next;
        pend_idx_reg    <= pend_idx_next;
        best_idx_reg    <= best_idx_next;
        best_size_reg   <= best_size_next;
        best_handle_reg <= best_handle_next;
        hit_reg         <= hit_next;
        pooled_reg      <= pooled_next;
        oh_reg          <= oh_next;
        os_reg          <= os_next;
        stored_reg      <= stored_next;
    end

    // count stays within the RAM
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(POOL_DEPTH))
        else $error("entry count beyond pool depth");

    // a response never reports both a hit and a store
    a_hit_stored: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(hit_reg && stored_reg))
        else $error("hit and stored together");

    // a hit always removes exactly one entry
    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT && state_next == ST_IDLE) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("hit did not remove one entry");

    // compaction only starts from a found entry
    a_shift_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> found_reg)
        else $error("shift without a match");
endmodule

### src/bfc_ram.sv
module bfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
